[hw/rtl/signed_integer_seven_segment_scan_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment scan block
// Shared property shapes, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_SEVEN_SEGMENT_SCAN_DEFINES_SVH
`define SIGNED_INTEGER_SEVEN_SEGMENT_SCAN_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define SSSCAN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante
`define SSSCAN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ssscan_pkg.sv]
// ----------------------------------------------------------------------------
// ssscan_pkg
// Types, widths, constants and the digit pattern table of the scan block.
// ----------------------------------------------------------------------------
package ssscan_pkg;

    // Field widths
    localparam int VALUE_W = 28;
    localparam int LOWER_W = 25;
    localparam int UPPER_W = 27;
    localparam int CFG_W   = 27;
    localparam int COL_W   = 4;
    localparam int SEG_W   = 8;
    localparam int MAG_W   = 27;
    localparam int DIGIT_W = 4;

    // Default cell count
    localparam int DIGIT_CELLS_DEF = 8;

    // Reciprocal of ten: q = (n * RECIP_TEN) >> RECIP_SHIFT, exact for n < 2**32
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 35;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

    // Reset values of the limit registers
    localparam logic [LOWER_W-1:0] LOWER_RST = 25'h1676981; // -9999999
    localparam logic [UPPER_W-1:0] UPPER_RST = 27'd99999999;

    // Minus sign lights line 2 only
    localparam logic [SEG_W-1:0] MINUS_LINES = 8'h02;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LOWER_LIMIT = 1'd0;
    localparam t_cfg_idx CFG_UPPER_LIMIT = 1'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIGIT,
        ST_MINUS
    } t_state;

    // Seven-segment pattern of a decimal digit
    function automatic logic [SEG_W-1:0] seg_of_digit(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'hFC;
            4'd1:    s = 8'h60;
            4'd2:    s = 8'hDA;
            4'd3:    s = 8'hF2;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'hB6;
            4'd6:    s = 8'hBE;
            4'd7:    s = 8'hE0;
            4'd8:    s = 8'hFE;
            4'd9:    s = 8'hF6;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

[hw/rtl/ssscan_in_if.sv]
// ----------------------------------------------------------------------------
// ssscan_in_if
// Request channel carrying one signed value to display.
// ----------------------------------------------------------------------------
interface ssscan_in_if;
    import ssscan_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[hw/rtl/ssscan_out_if.sv]
// ----------------------------------------------------------------------------
// ssscan_out_if
// Scan entry channel: column, segment line mask and last flag.
// ----------------------------------------------------------------------------
interface ssscan_out_if;
    import ssscan_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column;
    logic [SEG_W-1:0] segment_lines;
    logic             last_cell;

    modport source (output valid, output column, output segment_lines,
                    output last_cell, input ready);
    modport sink   (input valid, input column, input segment_lines,
                    input last_cell, output ready);
endinterface

[hw/rtl/ssscan_div10.sv]
// ----------------------------------------------------------------------------
// ssscan_div10
// Divide-by-ten unit: registered reciprocal product, then quotient/remainder.
// ----------------------------------------------------------------------------
module ssscan_div10 (
    input  logic                        i_clk,
    input  logic [ssscan_pkg::MAG_W-1:0]   i_mag,
    output logic [ssscan_pkg::MAG_W-1:0]   o_quot,
    output logic [ssscan_pkg::DIGIT_W-1:0] o_rem
);
    import ssscan_pkg::*;

    localparam int PROD_W = MAG_W + RECIP_W;

    logic [PROD_W-1:0] r_prod;
    logic [MAG_W-1:0]  r_mag;
    logic [MAG_W-1:0]  quot;
    logic [MAG_W-1:0]  times_ten;

    // Register the reciprocal product together with its operand
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_mag) * PROD_W'(RECIP_TEN);
        r_mag  <= i_mag;
    end

    // Take the quotient and the remainder from the registered product
    always_comb begin
        quot      = MAG_W'(r_prod[PROD_W-1:RECIP_SHIFT]);
        times_ten = (quot << 3) + (quot << 1);
    end

    assign o_quot = quot;
    assign o_rem  = DIGIT_W'(r_mag - times_ten);
endmodule

[hw/rtl/signed_integer_seven_segment_scan.sv]
// ----------------------------------------------------------------------------
// signed_integer_seven_segment_scan
// Range-checks a signed value, splits it into decimal digits and emits one
// seven-segment scan entry per occupied cell, rightmost cell first.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  i_in     in   valid/ready   value[27:0] signed
//  o_out    out  valid/ready   column[3:0], segment_lines[7:0], last_cell
//  i_cfg    in   i_cfg_we      i_cfg_index[0:0], i_cfg_data[26:0]
//
//  An item is accepted in ST_IDLE and range-checked in ST_CHECK, then each digit
//  passes through ST_MUL and ST_DIGIT using the shared divide-by-ten unit, and
//  a negative value ends with a minus sign in ST_MINUS. An out-of-range value
//  is dropped after the check. i_in.ready is high only while the sequencer is
//  idle; a stalled o_out holds the sequencer.
//  Reset is synchronous and restores the default limits.
// ----------------------------------------------------------------------------
`include "signed_integer_seven_segment_scan_defines.svh"

module signed_integer_seven_segment_scan #(
    parameter int DIGIT_CELLS = ssscan_pkg::DIGIT_CELLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ssscan_in_if.sink                     i_in,
    ssscan_out_if.source                  o_out,
    input  logic                          i_cfg_we,
    input  ssscan_pkg::t_cfg_idx          i_cfg_index,
    input  logic [ssscan_pkg::CFG_W-1:0]  i_cfg_data
);
    import ssscan_pkg::*;

    localparam int CELL_W = $clog2(DIGIT_CELLS + 1);

    t_state             r_state, n_state;
    logic [LOWER_W-1:0] r_lower, n_lower;
    logic [UPPER_W-1:0] r_upper, n_upper;
    logic [VALUE_W-1:0] r_value, n_value;
    logic               r_neg, n_neg;
    logic [MAG_W-1:0]   r_mag, n_mag;
    logic [CELL_W-1:0]  r_cell, n_cell;
    logic               r_out_valid, n_out_valid;
    logic [COL_W-1:0]   r_col, n_col;
    logic [SEG_W-1:0]   r_seg, n_seg;
    logic               r_last, n_last;

    logic [MAG_W-1:0]   quot;
    logic [DIGIT_W-1:0] rem;
    logic               slot_free;
    logic               below, above;
    logic [CELL_W-1:0]  stop_cell;
    logic               more_digits;

    // Shared divide-by-ten unit
    ssscan_div10 u_div10 (
        .i_clk  (i_clk),
        .i_mag  (r_mag),
        .o_quot (quot),
        .o_rem  (rem)
    );

    // Range compare against the limits
    always_comb begin
        below = $signed(r_value) < $signed({{(VALUE_W-LOWER_W){r_lower[LOWER_W-1]}}, r_lower});
        above = $signed(r_value) > $signed({{(VALUE_W-UPPER_W){1'b0}}, r_upper});
    end

    // Keep one cell free for the minus sign on negative values
    assign stop_cell   = r_neg ? CELL_W'(2) : CELL_W'(1);
    assign more_digits = (r_cell > stop_cell) && (quot != '0);
    assign slot_free   = !r_out_valid || o_out.ready;

    // Sequencer, configuration writes and output register
    always_comb begin
        n_state     = r_state;
        n_lower     = r_lower;
        n_upper     = r_upper;
        n_value     = r_value;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_cell      = r_cell;
        n_out_valid = r_out_valid && !o_out.ready;
        n_col       = r_col;
        n_seg       = r_seg;
        n_last      = r_last;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOWER_LIMIT: n_lower = i_cfg_data[LOWER_W-1:0];
                CFG_UPPER_LIMIT: n_upper = i_cfg_data[UPPER_W-1:0];
                default:         n_lower = r_lower;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_value = i_in.value;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // Drop values outside the limits
                if (below || above) begin
                    n_state = ST_IDLE;
                end else begin
                    n_neg   = r_value[VALUE_W-1];
                    n_mag   = r_value[VALUE_W-1] ? MAG_W'(-r_value)
                                                 : r_value[MAG_W-1:0];
                    n_cell  = CELL_W'(DIGIT_CELLS);
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DIGIT;
            end
            ST_DIGIT: begin
                // Emit one digit, then advance to the next cell
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_col       = COL_W'(r_cell);
                    n_seg       = seg_of_digit(rem);
                    n_last      = !r_neg && !more_digits;
                    n_mag       = quot;
                    n_cell      = r_cell - 1'b1;
                    if (more_digits) begin
                        n_state = ST_MUL;
                    end else if (r_neg) begin
                        n_state = ST_MINUS;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_MINUS: begin
                // Place the minus sign in the cell left of the last digit
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_col       = COL_W'(r_cell);
                    n_seg       = MINUS_LINES;
                    n_last      = 1'b1;
                    n_cell      = r_cell - 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold control and limit registers under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_lower     <= LOWER_RST;
            r_upper     <= UPPER_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_lower     <= n_lower;
            r_upper     <= n_upper;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_cell  <= n_cell;
        r_col   <= n_col;
        r_seg   <= n_seg;
        r_last  <= n_last;
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.column        = r_col;
    assign o_out.segment_lines = r_seg;
    assign o_out.last_cell     = r_last;

    // Sequencer checks
    `SSSCAN_ASSERT_NEXT(a_accept_to_check, i_in.valid && i_in.ready, r_state == ST_CHECK, "accepted request did not enter the range check")
    `SSSCAN_ASSERT_NOW(a_cell_nonzero, r_state == ST_DIGIT || r_state == ST_MINUS, r_cell != '0, "cell counter underflow")
    `SSSCAN_ASSERT_NOW(a_minus_only_neg, r_state == ST_MINUS, r_neg, "minus sign for a non-negative value")
    `SSSCAN_ASSERT_NEXT(a_check_exit, r_state == ST_CHECK, r_state == ST_IDLE || r_state == ST_MUL, "bad exit from range check")

endmodule
